/* hdl/u16u8_pkg.sv */
// Shared types, constants and the code point encoder for the UTF-16 to UTF-8 block.
package u16u8_pkg;

   localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
   localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
   localparam logic [15:0] LOW_SURR_HI  = 16'hDFFF;
   localparam logic [20:0] SUPP_BASE    = 21'h10000;
   localparam logic [7:0]  CONT_MARK    = 8'h80;

   // Lead byte marks indexed by byte count.
   localparam logic [6:0][7:0] LEAD_MARK = {8'hFC, 8'hF8, 8'hF0, 8'hE0, 8'hC0, 8'h00, 8'h00};

   // One code point (or one error result) worth of output bytes, lead byte in slot 0.
   typedef struct packed {
      logic            vld;
      logic            err;
      logic [2:0]      cnt;
      logic [3:0][7:0] bytes;
   } seg_type;

   // Everything one input item produces: an optional flushed surrogate, then the unit.
   typedef struct packed {
      seg_type a;
      seg_type b;
   } job_type;

   function automatic seg_type encode_cp(input logic [20:0] cp);
      seg_type s;
      s.vld   = 1'b1;
      s.err   = 1'b0;
      s.bytes = '0;
      if (cp < 21'h80) begin
         s.cnt      = 3'd1;
         s.bytes[0] = {1'b0, cp[6:0]} | LEAD_MARK[1];
      end else if (cp < 21'h800) begin
         s.cnt      = 3'd2;
         s.bytes[0] = {3'b000, cp[10:6]} | LEAD_MARK[2];
         s.bytes[1] = {2'b00, cp[5:0]} | CONT_MARK;
      end else if (cp < SUPP_BASE) begin
         s.cnt      = 3'd3;
         s.bytes[0] = {4'b0000, cp[15:12]} | LEAD_MARK[3];
         s.bytes[1] = {2'b00, cp[11:6]} | CONT_MARK;
         s.bytes[2] = {2'b00, cp[5:0]} | CONT_MARK;
      end else begin
         s.cnt      = 3'd4;
         s.bytes[0] = {5'b00000, cp[20:18]} | LEAD_MARK[4];
         s.bytes[1] = {2'b00, cp[17:12]} | CONT_MARK;
         s.bytes[2] = {2'b00, cp[11:6]} | CONT_MARK;
         s.bytes[3] = {2'b00, cp[5:0]} | CONT_MARK;
      end
      return s;
   endfunction

endpackage

/* hdl/u16u8_front.sv */
// Front end: classifies each code unit, pairs surrogates and builds one job per item.
module u16u8_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_accept,
   input  logic [15:0]       code_unit,
   input  logic              end_of_input,
   output logic              job_push,
   output u16u8_pkg::job_type job
);
   import u16u8_pkg::*;

   logic       held_valid_ff, held_valid_in;
   logic [9:0] held_hi_ff, held_hi_in;
   logic       is_high, is_low;
   seg_type    plain_seg, pair_seg, flush_seg;
   logic [20:0] pair_cp;

   assign is_high = (code_unit >= HIGH_SURR_LO) && (code_unit <= HIGH_SURR_HI);
   assign is_low  = (code_unit >= LOW_SURR_LO) && (code_unit <= LOW_SURR_HI);

   assign pair_cp   = {1'b0, held_hi_ff, code_unit[9:0]} + SUPP_BASE;
   assign pair_seg  = encode_cp(pair_cp);
   assign flush_seg = encode_cp({5'b00000, HIGH_SURR_LO[15:10], held_hi_ff});

   // Unit handled with nothing held: hold, flag an error, or encode.
   always_comb begin
      plain_seg = encode_cp({5'b00000, code_unit});
      if (is_high) begin
         plain_seg.vld   = end_of_input;
         plain_seg.err   = 1'b1;
         plain_seg.cnt   = 3'd1;
         plain_seg.bytes = '0;
      end
   end

   always_comb begin
      job.a = plain_seg;
      job.b = '0;
      if (held_valid_ff) begin
         if (is_low) begin
            job.a = pair_seg;
         end else begin
            job.a = flush_seg;
            job.b = plain_seg;
         end
      end
   end

   assign job_push = in_accept && (job.a.vld || job.b.vld);

   // Hold a high surrogate unless it ends the input.
   assign held_valid_in = in_accept ? (is_high && !end_of_input) : held_valid_ff;
   assign held_hi_in    = in_accept ? code_unit[9:0] : held_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_valid_ff <= 1'b0;
         held_hi_ff    <= '0;
      end else begin
         held_valid_ff <= held_valid_in;
         held_hi_ff    <= held_hi_in;
      end
   end

   a_last_clears_hold: assert property (@(posedge clock) disable iff (reset)
      (in_accept && end_of_input) |=> !held_valid_ff)
      else $error("hold survives the last unit");

   a_held_gives_job: assert property (@(posedge clock) disable iff (reset)
      (in_accept && held_valid_ff) |-> job_push)
      else $error("held surrogate dropped");

   a_silent_item_holds: assert property (@(posedge clock) disable iff (reset)
      (in_accept && !job_push) |=> held_valid_ff)
      else $error("item produced nothing and left nothing held");

endmodule

/* hdl/u16u8_queue.sv */
// Short job queue between front and back, in flip-flops.
module u16u8_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  u16u8_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output u16u8_pkg::job_type head_job
);
   import u16u8_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = (count_ff == FULL_CNT);
   assign head_valid = (count_ff != '0);
   assign head_job   = mem_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && head_valid;

   assign wr_ptr_in = !do_push ? wr_ptr_ff : (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_in = !do_pop ? rd_ptr_ff : (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count overflow");

   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == FULL_CNT) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers out of step");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("push lost");

endmodule

/* hdl/u16u8_back.sv */
// Back end: walks each job one byte a cycle into the result register while rsp_pop takes each byte.
module u16u8_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  u16u8_pkg::job_type head_job,
   output logic              head_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_run_last,
   output logic              rsp_error
);
   import u16u8_pkg::*;

   logic       seg_sel_ff, seg_sel_in;
   logic [1:0] idx_ff, idx_in;
   logic       out_vld_ff, out_vld_in;
   logic [7:0] out_byte_ff;
   logic       out_last_ff, out_err_ff;
   logic       cur_sel, seg_end, job_end, load, advance;
   seg_type    cur;

   // Skip an empty first segment.
   assign cur_sel = seg_sel_ff || !head_job.a.vld;
   assign cur     = cur_sel ? head_job.b : head_job.a;
   assign seg_end = ({1'b0, idx_ff} == (cur.cnt - 3'd1));
   assign job_end = seg_end && (cur_sel || !head_job.b.vld);

   assign load     = !out_vld_ff || rsp_pop;
   assign advance  = head_valid && load;
   assign head_pop = advance && job_end;

   always_comb begin
      seg_sel_in = seg_sel_ff;
      idx_in     = idx_ff;
      if (advance) begin
         if (job_end) begin
            seg_sel_in = 1'b0;
            idx_in     = '0;
         end else if (seg_end) begin
            seg_sel_in = 1'b1;
            idx_in     = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   assign out_vld_in = load ? head_valid : out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_sel_ff <= 1'b0;
         idx_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         seg_sel_ff <= seg_sel_in;
         idx_ff     <= idx_in;
         out_vld_ff <= out_vld_in;
      end
      if (advance) begin
         out_byte_ff <= cur.bytes[idx_ff];
         out_last_ff <= job_end;
         out_err_ff  <= cur.err;
      end
   end

   assign rsp_empty    = !out_vld_ff;
   assign rsp_out_byte = out_byte_ff;
   assign rsp_run_last = out_last_ff;
   assign rsp_error    = out_err_ff;

endmodule

/* hdl/utf16_to_utf8_encoder.sv */
// Top level of the UTF-16 to UTF-8 transcoder: front end, job queue and byte walker.
//
// Input channel: present one UTF-16 code unit on req_code_unit with req_end_of_input
// set on the last unit of a buffer, and raise req_push; the item is taken at a clock
// edge where req_full is low. Result channel: while rsp_empty is low, rsp_out_byte,
// rsp_run_last and rsp_error show the oldest waiting result; raise rsp_pop to take it.
// Each unit gives 0 to 6 results, lead byte first; rsp_run_last marks the final result
// of an item, and an unpaired high surrogate on the last unit gives one result with
// rsp_error set and a zero byte. A high surrogate that is not last gives no result
// until the next unit arrives.
// Order: an item's job is registered in the job queue and then its first byte in the
// result register. Throughput: the result register emits one byte per cycle while
// rsp_pop takes each byte, each item giving 0 to 6 bytes; the front takes one item
// per cycle until the job queue of QUEUE_DEPTH entries fills.
// Reset clears the held surrogate, the queue and the result register; no clearing pass.
// When the receiver stalls, the result register holds its byte, the back end waits,
// the queue fills, and req_full rises.
module utf16_to_utf8_encoder #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [15:0] req_code_unit,
   input  logic        req_end_of_input,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_error
);
   import u16u8_pkg::*;

   logic    in_accept;
   logic    job_push;
   job_type job;
   logic    head_valid, head_pop;
   job_type head_job;

   // Take an item whenever the queue has room.
   assign in_accept = req_push && !req_full;

   u16u8_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_accept    (in_accept),
      .code_unit    (req_code_unit),
      .end_of_input (req_end_of_input),
      .job_push     (job_push),
      .job          (job)
   );

   u16u8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (job),
      .full       (req_full),
      .pop        (head_pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   // Drain jobs one byte per cycle into the result register while rsp_pop takes each byte.
   u16u8_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head_job     (head_job),
      .head_pop     (head_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_run_last (rsp_run_last),
      .rsp_error    (rsp_error)
   );

   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_error) |-> (rsp_run_last && rsp_out_byte == 8'h00))
      else $error("error result malformed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("results visible after reset");

   a_idle_drains: assert property (@(posedge clock) disable iff (reset)
      (!head_valid && rsp_pop && !rsp_empty) |=> rsp_empty)
      else $error("result appeared with no job queued");

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the UTF-16 to UTF-8 transcoder.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import u16u8_pkg::*;

   // Give up after this many cycles in a row in which neither side moves an item.
   localparam int STALL_LIMIT   = 4000;
   // Cycles to wait after the last expected byte has arrived.
   localparam int SETTLE_CYCLES = 20;
   localparam int IDLE_PERCENT  = 35;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       err;
   } utf8_result_type;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_push         = 1'b0;
   logic        req_full;
   logic [15:0] req_code_unit    = '0;
   logic        req_end_of_input = 1'b0;
   logic        rsp_empty;
   logic        rsp_pop          = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_error;

   // Shadow copy of the surrogate holding register.
   logic        shadow_held      = 1'b0;
   logic [9:0]  shadow_high_bits = '0;

   utf8_result_type utf8_expected[$];
   // Bytes produced by the unit being predicted, before run_last is marked.
   utf8_result_type unit_bytes[$];

   int  fail_count   = 0;
   int  units_sent   = 0;
   int  quiet_cycles = 0;
   // While set, neither side idles.
   logic steady     = 1'b0;

   utf16_to_utf8_encoder uut (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_code_unit    (req_code_unit),
      .req_end_of_input (req_end_of_input),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_run_last     (rsp_run_last),
      .rsp_error        (rsp_error)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic draw_idle();
      return !steady && ($urandom_range(99) < IDLE_PERCENT);
   endfunction

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // Append the UTF-8 bytes of one code point, lead byte first.
   task automatic add_code_point(input logic [20:0] cp);
      logic [7:0]      b [4];
      logic [20:0]     rest;
      int              n;
      utf8_result_type r;
      rest = cp;
      if (cp < 21'h80)
         n = 1;
      else if (cp < 21'h800)
         n = 2;
      else if (cp < SUPP_BASE)
         n = 3;
      else
         n = 4;
      // Peel six bits per continuation byte from the low end.
      for (int i = n - 1; i > 0; i--) begin
         b[i] = {2'b00, rest[5:0]} | CONT_MARK;
         rest = rest >> 6;
      end
      b[0] = rest[7:0] | LEAD_MARK[n];
      for (int i = 0; i < n; i++) begin
         r.data = b[i];
         r.last = 1'b0;
         r.err  = 1'b0;
         unit_bytes.push_back(r);
      end
   endtask

   // Handle a unit with nothing held: hold a high surrogate, flag one that ends the input, else encode it.
   task automatic add_fresh_unit(input logic [15:0] cu, input logic eoi);
      utf8_result_type r;
      if (cu >= HIGH_SURR_LO && cu <= HIGH_SURR_HI) begin
         if (eoi) begin
            r.data = 8'h00;
            r.last = 1'b0;
            r.err  = 1'b1;
            unit_bytes.push_back(r);
         end else begin
            shadow_held      = 1'b1;
            shadow_high_bits = cu[9:0];
         end
      end else begin
         add_code_point({5'b0, cu});
      end
   endtask

   // Work out every result of one accepted unit and queue them.
   task automatic predict_utf8_bytes(input logic [15:0] cu, input logic eoi);
      logic [9:0]      hi;
      logic [20:0]     cp;
      utf8_result_type r;
      unit_bytes.delete();
      if (shadow_held) begin
         hi               = shadow_high_bits;
         shadow_held      = 1'b0;
         shadow_high_bits = '0;
         if (cu >= LOW_SURR_LO && cu <= LOW_SURR_HI) begin
            cp = {1'b0, hi, 10'b0} + {5'b0, cu - LOW_SURR_LO} + SUPP_BASE;
            add_code_point(cp);
         end else begin
            add_code_point({5'b0, HIGH_SURR_LO} + {11'b0, hi});
            add_fresh_unit(cu, eoi);
         end
      end else begin
         add_fresh_unit(cu, eoi);
      end
      foreach (unit_bytes[i]) begin
         r      = unit_bytes[i];
         r.last = (i == unit_bytes.size() - 1);
         utf8_expected.push_back(r);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      fail_count++;
   endtask

   // Sample both handshakes at the edge, compare each popped byte, then redraw pop.
   always @(posedge clock) begin
      utf8_result_type want;
      if (!reset) begin
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (rsp_pop && !rsp_empty) begin
            if (utf8_expected.size() == 0) begin
               report_mismatch("unexpected result byte", int'(rsp_out_byte), 0);
            end else begin
               want = utf8_expected.pop_front();
               if (rsp_out_byte !== want.data)
                  report_mismatch("out_byte", int'(rsp_out_byte), int'(want.data));
               if (rsp_run_last !== want.last)
                  report_mismatch("run_last", int'(rsp_run_last), int'(want.last));
               if (rsp_error !== want.err)
                  report_mismatch("error", int'(rsp_error), int'(want.err));
            end
         end
         rsp_pop <= !draw_idle();
      end
   end

   // End the run if traffic stops for too long.
   initial begin
      while (quiet_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("Watchdog expired after %0d quiet cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------

   // Offer one unit, holding it until the block takes it, then predict its bytes.
   task automatic send_unit(input logic [15:0] cu, input logic eoi);
      while (draw_idle()) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push         <= 1'b1;
      req_code_unit    <= cu;
      req_end_of_input <= eoi;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      predict_utf8_bytes(cu, eoi);
      units_sent++;
   endtask

   // Drop push and hold until every predicted byte has been popped.
   task automatic wait_drained();
      req_push <= 1'b0;
      @(posedge clock);
      while (utf8_expected.size() != 0)
         @(posedge clock);
   endtask

   // Range edges of the one, two and three byte forms, plus bit patterns.
   task automatic test_unit_boundaries();
      send_unit(16'h0000, 1'b0);
      send_unit(16'h007F, 1'b0);
      send_unit(16'h0080, 1'b1);
      send_unit(16'h07FF, 1'b0);
      send_unit(16'h0800, 1'b0);
      send_unit(16'hD7FF, 1'b0);
      send_unit(16'hE000, 1'b0);
      send_unit(16'hAAAA, 1'b0);
      send_unit(16'h5555, 1'b1);
      send_unit(16'hFFFF, 1'b1);
      wait_drained();
   endtask

   // Pairs, lone surrogates, flushes and the unpaired high surrogate at the end.
   task automatic test_surrogate_cases();
      // Lowest and highest pair, the second one ending the input.
      send_unit(16'hD800, 1'b0);
      send_unit(16'hDC00, 1'b0);
      send_unit(16'hDBFF, 1'b0);
      send_unit(16'hDFFF, 1'b1);
      // Lone low surrogates.
      send_unit(16'hDC00, 1'b0);
      send_unit(16'hDFFF, 1'b1);
      // Held surrogate flushed by plain text.
      send_unit(16'hD83D, 1'b0);
      send_unit(16'h0041, 1'b0);
      // Flushed by another high surrogate, which is held and then paired.
      send_unit(16'hDABC, 1'b0);
      send_unit(16'hDB00, 1'b0);
      send_unit(16'hDE00, 1'b0);
      // Flushed by a high surrogate that ends the input: flush, then error.
      send_unit(16'hD900, 1'b0);
      send_unit(16'hDA00, 1'b1);
      // Unpaired high surrogate at the end with nothing held.
      send_unit(16'hDBFF, 1'b1);
      wait_drained();
   endtask

   // Hold a high surrogate, then pause the sender until the output has drained.
   task automatic test_pause_while_held();
      send_unit(16'h00E9, 1'b0);
      send_unit(16'hD834, 1'b0);
      wait_drained();
      repeat ($urandom_range(8, 2)) @(posedge clock);
      send_unit(16'hDD1E, 1'b0);
      wait_drained();
   endtask

   // Send one well-formed character, or one broken surrogate sequence.
   task automatic send_random_char();
      logic eoi;
      eoi = ($urandom_range(9) == 0);
      case ($urandom_range(9)) inside
         [0:1]: send_unit(16'($urandom_range(16'h007F)), eoi);
         [2:3]: send_unit(16'($urandom_range(16'h07FF, 16'h0080)), eoi);
         4: send_unit(16'($urandom_range(16'hD7FF, 16'h0800)), eoi);
         5: send_unit(16'($urandom_range(16'hFFFF, 16'hE000)), eoi);
         [6:7]: begin
            send_unit(16'($urandom_range(HIGH_SURR_HI, HIGH_SURR_LO)), 1'b0);
            send_unit(16'($urandom_range(LOW_SURR_HI, LOW_SURR_LO)), eoi);
         end
         8: send_unit(16'($urandom_range(LOW_SURR_HI, LOW_SURR_LO)), eoi);
         default: begin
            // A high surrogate that is either cut off or followed by an arbitrary unit.
            send_unit(16'($urandom_range(HIGH_SURR_HI, HIGH_SURR_LO)),
                      $urandom_range(3) == 0);
            send_unit(16'($urandom_range(16'hFFFF)), eoi);
         end
      endcase
   endtask

   // Random text with idling on both sides.
   task automatic test_random_text(input int count);
      int stop;
      stop = units_sent + count;
      while (units_sent < stop)
         send_random_char();
   endtask

   // Back-to-back text with neither side idling.
   task automatic test_steady_stream(input int count);
      int stop;
      stop   = units_sent + count;
      steady = 1'b1;
      while (units_sent < stop)
         send_random_char();
      steady = 1'b0;
   endtask

   // Arbitrary code units with random end flags.
   task automatic test_raw_noise(input int count);
      repeat (count)
         send_unit(16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)));
   endtask

   initial begin
      // Hold reset, then release it at an edge.
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_unit_boundaries();
      test_surrogate_cases();
      test_pause_while_held();
      test_random_text(60);
      test_steady_stream(40);
      test_raw_noise(25);
      test_random_text(20);

      // Drain, then let the pipeline settle before the final check.
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (utf8_expected.size() != 0)
         report_mismatch("bytes never delivered", 0, utf8_expected.size());

      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

/* files.f */
hdl/u16u8_pkg.sv
hdl/u16u8_front.sv
hdl/u16u8_queue.sv
hdl/u16u8_back.sv
hdl/utf16_to_utf8_encoder.sv
tb/sv/tb.sv
